// ===== rtl/core/affine_sprite_blit_macros.svh =====
// Assertion macros for the affine sprite blitter.
// Included by the top level; no other dependencies.
`ifndef AFFINE_SPRITE_BLIT_MACROS_SVH
`define AFFINE_SPRITE_BLIT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASB_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASB_ASSERT(lbl, clk, rst_n, prop, msg)
`define ASB_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/asb_pkg.sv =====
// Shared types and constants of the affine sprite blitter.
// Used by every module in rtl/core; depends on nothing.
package asb_pkg;

    localparam int COEF_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DEST_W    = 10;
    localparam int SIZE_W    = 7;
    localparam int ADDR_W    = 12;
    localparam int KEY_W     = 8;
    localparam int COLOR_W   = 32;
    localparam int PAL_AW    = 8;
    localparam int PAL_DEPTH = 256;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int NSTAGE    = 5;
    // 11-bit signed coordinate times 32-bit signed coefficient.
    localparam int PROD_W    = DEST_W + 1 + COEF_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int COORD_W   = SUM_W - FRAC_BITS;

    localparam logic [CMD_W-1:0] CMD_TEXEL   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PALETTE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAW    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_U_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_U_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_U = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_V_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_V_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_V = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd7;

    typedef struct packed {
        logic [COEF_W-1:0] coef_u_from_x;
        logic [COEF_W-1:0] coef_u_from_y;
        logic [COEF_W-1:0] offset_u;
        logic [COEF_W-1:0] coef_v_from_x;
        logic [COEF_W-1:0] coef_v_from_y;
        logic [COEF_W-1:0] offset_v;
        logic [SIZE_W-1:0] sprite_width;
        logic [SIZE_W-1:0] sprite_height;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [ADDR_W-1:0]  address;
        logic [COLOR_W-1:0] value;
        logic [DEST_W-1:0]  dest_x;
        logic [DEST_W-1:0]  dest_y;
        logic [KEY_W-1:0]   key;
    } t_item;

    // Per-stage load enables and occupancy, index 0 is the first stage.
    typedef struct packed {
        logic [NSTAGE-1:0] en;
        logic [NSTAGE-1:0] vld;
    } t_pipe_ctl;

endpackage

// ===== rtl/core/asb_xform.sv =====
// Stages 1 and 2: affine products, then sums floored to texel coordinates.
// Depends on asb_pkg.
module asb_xform (
    input  logic                            i_clk,
    input  asb_pkg::t_pipe_ctl              i_ctl,
    input  asb_pkg::t_cfg                   i_cfg,
    input  asb_pkg::t_item                  i_item,
    output asb_pkg::t_item                  o_item,
    output logic [asb_pkg::COORD_W-1:0]     o_u,
    output logic [asb_pkg::COORD_W-1:0]     o_v
);

    logic signed [asb_pkg::DEST_W:0]   x_s;
    logic signed [asb_pkg::DEST_W:0]   y_s;
    logic signed [asb_pkg::PROD_W-1:0] n_pux, n_puy, n_pvx, n_pvy;
    logic signed [asb_pkg::PROD_W-1:0] r1_pux, r1_puy, r1_pvx, r1_pvy;
    logic signed [asb_pkg::SUM_W-1:0]  n_su, n_sv;
    asb_pkg::t_item                    r1_item;
    asb_pkg::t_item                    r2_item;
    logic [asb_pkg::COORD_W-1:0]       r2_u, r2_v;

    assign x_s = $signed({1'b0, i_item.dest_x});
    assign y_s = $signed({1'b0, i_item.dest_y});

    assign n_pux = x_s * $signed(i_cfg.coef_u_from_x);
    assign n_puy = y_s * $signed(i_cfg.coef_u_from_y);
    assign n_pvx = x_s * $signed(i_cfg.coef_v_from_x);
    assign n_pvy = y_s * $signed(i_cfg.coef_v_from_y);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r1_item <= i_item;
            r1_pux  <= n_pux;
            r1_puy  <= n_puy;
            r1_pvx  <= n_pvx;
            r1_pvy  <= n_pvy;
        end
    end

    assign n_su = asb_pkg::SUM_W'(r1_pux) + asb_pkg::SUM_W'(r1_puy)
                + asb_pkg::SUM_W'($signed(i_cfg.offset_u));
    assign n_sv = asb_pkg::SUM_W'(r1_pvx) + asb_pkg::SUM_W'(r1_pvy)
                + asb_pkg::SUM_W'($signed(i_cfg.offset_v));

    // Dropping the fraction bits of a two's complement value is a floor.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r2_item <= r1_item;
            r2_u    <= n_su[asb_pkg::SUM_W-1:asb_pkg::FRAC_BITS];
            r2_v    <= n_sv[asb_pkg::SUM_W-1:asb_pkg::FRAC_BITS];
        end
    end

    assign o_item = r2_item;
    assign o_u    = r2_u;
    assign o_v    = r2_v;

endmodule

// ===== rtl/core/asb_texfetch.sv =====
// Stages 3 and 4: sprite bounds check, texel address, texel store access.
// Depends on asb_pkg.
module asb_texfetch #(
    parameter int ROW_PITCH = 64,
    parameter int TEX_ROWS  = 64
) (
    input  logic                            i_clk,
    input  asb_pkg::t_pipe_ctl              i_ctl,
    input  asb_pkg::t_cfg                   i_cfg,
    input  asb_pkg::t_item                  i_item,
    input  logic [asb_pkg::COORD_W-1:0]     i_u,
    input  logic [asb_pkg::COORD_W-1:0]     i_v,
    output asb_pkg::t_item                  o_item,
    output logic                            o_hit,
    output logic [asb_pkg::KEY_W-1:0]       o_texel
);

    localparam int TEX_DEPTH = ROW_PITCH * TEX_ROWS;
    localparam int TAW       = $clog2(TEX_DEPTH);
    localparam int PITCH_W   = $clog2(ROW_PITCH + 1);
    localparam int CALC_A    = asb_pkg::SIZE_W + PITCH_W + 1;
    localparam int CALC_B    = (TAW + 1 > asb_pkg::ADDR_W + 1) ? TAW + 1 : asb_pkg::ADDR_W + 1;
    localparam int CALC_W    = (CALC_A > CALC_B) ? CALC_A : CALC_B;

    logic                         in_u, in_v;
    logic [CALC_W-1:0]            draw_addr;
    logic [CALC_W-1:0]            load_addr;
    logic                         is_draw;
    logic                         n_hit, n_twe;
    logic [TAW-1:0]               n_taddr;

    asb_pkg::t_item               r3_item;
    logic                         r3_hit, r3_twe;
    logic [TAW-1:0]               r3_taddr;
    asb_pkg::t_item               r4_item;
    logic                         r4_hit;
    logic [asb_pkg::KEY_W-1:0]    r4_texel;
    logic [asb_pkg::KEY_W-1:0]    r_tex_mem [TEX_DEPTH];

    // Coordinates are nonnegative when the sign bit is clear; the remaining bits
    // are then compared against the size registers.
    assign in_u = !i_u[asb_pkg::COORD_W-1]
               && (i_u[asb_pkg::COORD_W-2:0] < (asb_pkg::COORD_W-1)'(i_cfg.sprite_width));
    assign in_v = !i_v[asb_pkg::COORD_W-1]
               && (i_v[asb_pkg::COORD_W-2:0] < (asb_pkg::COORD_W-1)'(i_cfg.sprite_height));

    // Inside the sprite both coordinates are below 128, so seven bits suffice.
    assign draw_addr = CALC_W'(i_u[asb_pkg::SIZE_W-1:0])
                     + CALC_W'(i_v[asb_pkg::SIZE_W-1:0]) * CALC_W'(ROW_PITCH);
    assign load_addr = CALC_W'(i_item.address);
    assign is_draw   = (i_item.command == asb_pkg::CMD_DRAW);

    assign n_hit   = is_draw && in_u && in_v && (draw_addr < CALC_W'(TEX_DEPTH));
    assign n_twe   = (i_item.command == asb_pkg::CMD_TEXEL) && (load_addr < CALC_W'(TEX_DEPTH));
    assign n_taddr = is_draw ? draw_addr[TAW-1:0] : load_addr[TAW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r3_item  <= i_item;
            r3_hit   <= n_hit;
            r3_twe   <= n_twe;
            r3_taddr <= n_taddr;
        end
    end

    // Loads and reads meet the store at the same stage, so request order is kept.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r4_item  <= r3_item;
            r4_hit   <= r3_hit;
            r4_texel <= r_tex_mem[r3_taddr];
            if (i_ctl.vld[2] && r3_twe) begin
                r_tex_mem[r3_taddr] <= r3_item.value[asb_pkg::KEY_W-1:0];
            end
        end
    end

    assign o_item  = r4_item;
    assign o_hit   = r4_hit;
    assign o_texel = r4_texel;

endmodule

// ===== rtl/core/asb_palout.sv =====
// Stage 5: color key test, palette store access and the output register.
// Depends on asb_pkg.
module asb_palout (
    input  logic                            i_clk,
    input  asb_pkg::t_pipe_ctl              i_ctl,
    input  asb_pkg::t_item                  i_item,
    input  logic                            i_hit,
    input  logic [asb_pkg::KEY_W-1:0]       i_texel,
    output logic                            o_write_pixel,
    output logic [asb_pkg::DEST_W-1:0]      o_out_x,
    output logic [asb_pkg::DEST_W-1:0]      o_out_y,
    output logic [asb_pkg::COLOR_W-1:0]     o_pixel_color
);

    logic                          is_draw;
    logic                          n_pwe;
    logic                          r5_wp;
    logic [asb_pkg::DEST_W-1:0]    r5_x, r5_y;
    logic [asb_pkg::COLOR_W-1:0]   r5_color;
    logic [asb_pkg::COLOR_W-1:0]   r_pal_mem [asb_pkg::PAL_DEPTH];

    assign is_draw = (i_item.command == asb_pkg::CMD_DRAW);
    assign n_pwe   = (i_item.command == asb_pkg::CMD_PALETTE)
                  && (i_item.address[asb_pkg::ADDR_W-1:asb_pkg::PAL_AW] == '0);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r5_wp    <= i_hit && (i_texel != i_item.key);
            r5_x     <= is_draw ? i_item.dest_x : '0;
            r5_y     <= is_draw ? i_item.dest_y : '0;
            r5_color <= r_pal_mem[i_texel];
            if (i_ctl.vld[3] && n_pwe) begin
                r_pal_mem[i_item.address[asb_pkg::PAL_AW-1:0]] <= i_item.value;
            end
        end
    end

    assign o_write_pixel = r5_wp;
    assign o_out_x       = r5_x;
    assign o_out_y       = r5_y;
    assign o_pixel_color = r5_wp ? r5_color : '0;

endmodule

// ===== rtl/core/affine_sprite_blit.sv =====
// Affine sprite blitter: per destination pixel, a color-keyed texel lookup
// through a 16.16 fixed-point 2x3 matrix, a sprite store and a palette.
// Input request channel: i_valid/o_ready with command, address, value,
// dest_x, dest_y and transparent_index. Output channel: o_valid/i_ready
// with write_pixel, out_x, out_y and pixel_color. Every request returns
// exactly one result, loads included.
// Configuration: i_cfg_we writes register i_cfg_index from i_cfg_data
// (coefficients, offsets, sprite size); the user writes them only while
// the pipe is empty, which the block does not check. One request per
// cycle is taken when o_ready is high: a five stage pipeline (products,
// sums, bounds/address, texel store, palette store) where each store is
// read and written at a single stage. Reset clears the configuration to
// the identity mapping with a 64x64 sprite and empties the pipeline; the
// stores hold no reset value and must be loaded before a draw reads them.
// When the receiver stalls, results stay in place and bubbles ahead of the
// stall are squeezed out, so up to five requests are held before o_ready
// drops.
// Depends on asb_pkg, asb_xform, asb_texfetch, asb_palout.
`include "affine_sprite_blit_macros.svh"
module affine_sprite_blit #(
    parameter int ROW_PITCH = 64,
    parameter int TEX_ROWS  = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [asb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [asb_pkg::COEF_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [asb_pkg::CMD_W-1:0]         i_command,
    input  logic [asb_pkg::ADDR_W-1:0]        i_address,
    input  logic [asb_pkg::COLOR_W-1:0]       i_value,
    input  logic [asb_pkg::DEST_W-1:0]        i_dest_x,
    input  logic [asb_pkg::DEST_W-1:0]        i_dest_y,
    input  logic [asb_pkg::KEY_W-1:0]         i_transparent_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_write_pixel,
    output logic [asb_pkg::DEST_W-1:0]        o_out_x,
    output logic [asb_pkg::DEST_W-1:0]        o_out_y,
    output logic [asb_pkg::COLOR_W-1:0]       o_pixel_color
);

    asb_pkg::t_cfg                   r_cfg;
    logic [asb_pkg::NSTAGE-1:0]      r_vld;
    logic [asb_pkg::NSTAGE-1:0]      stage_en;
    asb_pkg::t_pipe_ctl              ctl;
    asb_pkg::t_item                  in_item;
    asb_pkg::t_item                  xf_item;
    logic [asb_pkg::COORD_W-1:0]     xf_u, xf_v;
    asb_pkg::t_item                  tf_item;
    logic                            tf_hit;
    logic [asb_pkg::KEY_W-1:0]       tf_texel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_u_from_x <= 32'sd65536;
            r_cfg.coef_u_from_y <= '0;
            r_cfg.offset_u      <= '0;
            r_cfg.coef_v_from_x <= '0;
            r_cfg.coef_v_from_y <= 32'sd65536;
            r_cfg.offset_v      <= '0;
            r_cfg.sprite_width  <= 7'd64;
            r_cfg.sprite_height <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                asb_pkg::REG_COEF_U_X: r_cfg.coef_u_from_x <= i_cfg_data;
                asb_pkg::REG_COEF_U_Y: r_cfg.coef_u_from_y <= i_cfg_data;
                asb_pkg::REG_OFFSET_U: r_cfg.offset_u      <= i_cfg_data;
                asb_pkg::REG_COEF_V_X: r_cfg.coef_v_from_x <= i_cfg_data;
                asb_pkg::REG_COEF_V_Y: r_cfg.coef_v_from_y <= i_cfg_data;
                asb_pkg::REG_OFFSET_V: r_cfg.offset_v      <= i_cfg_data;
                asb_pkg::REG_WIDTH:    r_cfg.sprite_width  <= i_cfg_data[asb_pkg::SIZE_W-1:0];
                asb_pkg::REG_HEIGHT:   r_cfg.sprite_height <= i_cfg_data[asb_pkg::SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A stage loads when it is empty or its occupant moves on.
    always_comb begin
        stage_en[asb_pkg::NSTAGE-1] = !r_vld[asb_pkg::NSTAGE-1] || i_ready;
        for (int k = asb_pkg::NSTAGE - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < asb_pkg::NSTAGE; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign ctl.en  = stage_en;
    assign ctl.vld = r_vld;

    assign in_item.command = i_command;
    assign in_item.address = i_address;
    assign in_item.value   = i_value;
    assign in_item.dest_x  = i_dest_x;
    assign in_item.dest_y  = i_dest_y;
    assign in_item.key     = i_transparent_index;

    asb_xform u_xform (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_cfg  (r_cfg),
        .i_item (in_item),
        .o_item (xf_item),
        .o_u    (xf_u),
        .o_v    (xf_v)
    );

    asb_texfetch #(
        .ROW_PITCH (ROW_PITCH),
        .TEX_ROWS  (TEX_ROWS)
    ) u_texfetch (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_cfg   (r_cfg),
        .i_item  (xf_item),
        .i_u     (xf_u),
        .i_v     (xf_v),
        .o_item  (tf_item),
        .o_hit   (tf_hit),
        .o_texel (tf_texel)
    );

    asb_palout u_palout (
        .i_clk         (i_clk),
        .i_ctl         (ctl),
        .i_item        (tf_item),
        .i_hit         (tf_hit),
        .i_texel       (tf_texel),
        .o_write_pixel (o_write_pixel),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_pixel_color (o_pixel_color)
    );

    assign o_ready = stage_en[0];
    assign o_valid = r_vld[asb_pkg::NSTAGE-1];

    // A free output slot must open the whole pipe to new requests.
    `ASB_ASSERT(a_ready_when_drain, i_clk, i_rst_n, (!o_valid || i_ready) |-> o_ready, "pipe blocked with free output")
    // A request held in the first stage under back-pressure must not vanish.
    `ASB_ASSERT(a_stage1_kept, i_clk, i_rst_n, (r_vld[0] && !o_ready) |=> r_vld[0], "stalled request lost")
    // Reset empties the pipeline.
    `ASB_ASSERT_NORST(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result after reset")

endmodule

// ===== test/affine_sprite_blit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for affine_sprite_blit: directed and random load and draw requests,
// with random idling on both handshakes, checked against an in-bench pixel predictor.
// Depends on asb_pkg and the affine_sprite_blit RTL.
module affine_sprite_blit_tb;
    import asb_pkg::*;

    localparam int ROW_PITCH = 64;
    localparam int TEX_ROWS = 64;
    localparam int TEX_DEPTH = ROW_PITCH * TEX_ROWS;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint S32_MAX = 64'sd2147483647;

    typedef enum {XF_RANDOM, XF_AXIS, XF_EXTREME, XF_WIDE, XF_EMPTY} xform_kind_t;

    typedef struct packed {
        logic               write_pixel;
        logic [DEST_W-1:0]  out_x;
        logic [DEST_W-1:0]  out_y;
        logic [COLOR_W-1:0] pixel_color;
    } pixel_write_t;

    typedef struct packed {
        t_item        req;
        pixel_write_t wr;
    } blit_job_t;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COEF_W-1:0]    i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [CMD_W-1:0]     i_command = '0;
    logic [ADDR_W-1:0]    i_address = '0;
    logic [COLOR_W-1:0]   i_value = '0;
    logic [DEST_W-1:0]    i_dest_x = '0;
    logic [DEST_W-1:0]    i_dest_y = '0;
    logic [KEY_W-1:0]     i_transparent_index = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_write_pixel;
    logic [DEST_W-1:0]    o_out_x;
    logic [DEST_W-1:0]    o_out_y;
    logic [COLOR_W-1:0]   o_pixel_color;

    // Predictor state: mapping registers and both stores, with written flags so that
    // no draw is ever generated that would read an entry that was never loaded.
    t_cfg               xform;
    logic [7:0]         texels [TEX_DEPTH];
    bit                 texel_loaded [TEX_DEPTH];
    logic [COLOR_W-1:0] palette [PAL_DEPTH];
    bit                 palette_loaded [PAL_DEPTH];

    blit_job_t    blit_jobs [$];
    pixel_write_t expected_writes [$];
    blit_job_t    in_flight;
    int           send_gap = 0;
    int           recv_stall = 0;
    int           mismatches = 0;
    int           cycle_count = 0;
    bit           calm = 1'b0;

    affine_sprite_blit #(
        .ROW_PITCH(ROW_PITCH),
        .TEX_ROWS (TEX_ROWS)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_command          (i_command),
        .i_address          (i_address),
        .i_value            (i_value),
        .i_dest_x           (i_dest_x),
        .i_dest_y           (i_dest_y),
        .i_transparent_index(i_transparent_index),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_write_pixel      (o_write_pixel),
        .o_out_x            (o_out_x),
        .o_out_y            (o_out_y),
        .o_pixel_color      (o_pixel_color)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Maps a destination pixel to a texel address. Returns 1 only when the texel lies
    // inside the sprite and inside the store.
    function automatic bit sprite_hit(input logic [DEST_W-1:0] x, input logic [DEST_W-1:0] y,
                                      output int addr);
        longint su, sv, u, v, a;
        su = longint'(x) * longint'($signed(xform.coef_u_from_x))
           + longint'(y) * longint'($signed(xform.coef_u_from_y))
           + longint'($signed(xform.offset_u));
        sv = longint'(x) * longint'($signed(xform.coef_v_from_x))
           + longint'(y) * longint'($signed(xform.coef_v_from_y))
           + longint'($signed(xform.offset_v));
        u = su >>> FRAC_BITS;
        v = sv >>> FRAC_BITS;
        a = u + v * ROW_PITCH;
        addr = int'(a);
        return u >= 0 && v >= 0 && u < longint'(xform.sprite_width)
            && v < longint'(xform.sprite_height) && a < TEX_DEPTH;
    endfunction

    function automatic bit draw_is_safe(input t_item r);
        int addr;
        if (!sprite_hit(r.dest_x, r.dest_y, addr))
            return 1'b1;
        if (!texel_loaded[addr])
            return 1'b0;
        return texels[addr] == r.key || palette_loaded[texels[addr]];
    endfunction

    // Applies one request to the predictor state and returns the pixel write it causes.
    function automatic pixel_write_t blit_pixel(input t_item r);
        pixel_write_t w;
        int addr;
        w = '0;
        case (r.command)
            CMD_TEXEL: begin
                if (r.address < TEX_DEPTH) begin
                    texels[r.address] = r.value[7:0];
                    texel_loaded[r.address] = 1'b1;
                end
            end
            CMD_PALETTE: begin
                if (r.address < PAL_DEPTH) begin
                    palette[r.address] = r.value;
                    palette_loaded[r.address] = 1'b1;
                end
            end
            CMD_DRAW: begin
                w.out_x = r.dest_x;
                w.out_y = r.dest_y;
                if (sprite_hit(r.dest_x, r.dest_y, addr) && texels[addr] != r.key) begin
                    w.write_pixel = 1'b1;
                    w.pixel_color = palette[texels[addr]];
                end
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic t_item random_req(input logic [CMD_W-1:0] cmd);
        t_item r;
        r.command = cmd;
        r.address = ADDR_W'($urandom);
        r.value = $urandom;
        r.dest_x = DEST_W'($urandom);
        r.dest_y = DEST_W'($urandom);
        r.key = KEY_W'($urandom);
        return r;
    endfunction

    function automatic int pick_size();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return $urandom_range(1, 16);
        if (roll < 9)
            return 64;
        return $urandom_range(1, 127);
    endfunction

    function automatic longint pick_extreme();
        return $urandom_range(0, 1) ? S32_MIN : S32_MAX;
    endfunction

    task automatic queue_request(input t_item r);
        blit_job_t job;
        job.req = r;
        job.wr = blit_pixel(r);
        blit_jobs.push_back(job);
    endtask

    task automatic send_texel(input int addr, input logic [31:0] value);
        t_item r;
        r = random_req(CMD_TEXEL);
        r.address = ADDR_W'(addr);
        r.value = value;
        queue_request(r);
    endtask

    task automatic send_palette(input int addr, input logic [COLOR_W-1:0] color);
        t_item r;
        r = random_req(CMD_PALETTE);
        r.address = ADDR_W'(addr);
        r.value = color;
        queue_request(r);
    endtask

    task automatic try_draw(input int x, input int y, input logic [KEY_W-1:0] key,
                            output bit sent);
        t_item r;
        r = random_req(CMD_DRAW);
        r.dest_x = DEST_W'(x);
        r.dest_y = DEST_W'(y);
        r.key = key;
        sent = draw_is_safe(r);
        if (sent)
            queue_request(r);
    endtask

    // Waits until every queued request is taken and every result has come back,
    // then lets the pipeline settle.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (blit_jobs.size() != 0 || i_valid || expected_writes.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_COEF_U_X: xform.coef_u_from_x = data;
            REG_COEF_U_Y: xform.coef_u_from_y = data;
            REG_OFFSET_U: xform.offset_u = data;
            REG_COEF_V_X: xform.coef_v_from_x = data;
            REG_COEF_V_Y: xform.coef_v_from_y = data;
            REG_OFFSET_V: xform.offset_v = data;
            REG_WIDTH:    xform.sprite_width = data[SIZE_W-1:0];
            REG_HEIGHT:   xform.sprite_height = data[SIZE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Size registers get random upper bits, which the block must drop.
    task automatic program_xform(input t_cfg c);
        wait_drained();
        write_reg(REG_COEF_U_X, c.coef_u_from_x);
        write_reg(REG_COEF_U_Y, c.coef_u_from_y);
        write_reg(REG_OFFSET_U, c.offset_u);
        write_reg(REG_COEF_V_X, c.coef_v_from_x);
        write_reg(REG_COEF_V_Y, c.coef_v_from_y);
        write_reg(REG_OFFSET_V, c.offset_v);
        write_reg(REG_WIDTH, {25'($urandom), c.sprite_width});
        write_reg(REG_HEIGHT, {25'($urandom), c.sprite_height});
    endtask

    // One mapping setting: pick a matrix that sends a destination origin onto a
    // target texel, load the texels around it and their colors, then draw mostly
    // near the origin, mixed with loads, unused commands and stray draws.
    task automatic run_phase(input xform_kind_t kind, input int n_req);
        t_cfg c;
        longint au, bu, av, bv, ou, ov;
        int sw, sh, tu, tv, ox, oy, made, tries, u, v, a, x, y, roll;
        logic [7:0] inks [4];
        logic [KEY_W-1:0] key;
        bit sent;
        t_item r;

        case (kind)
            XF_EMPTY: begin
                sw = 0;
                sh = $urandom_range(1, 64);
                if ($urandom_range(0, 1)) begin
                    sw = sh;
                    sh = 0;
                end
            end
            XF_WIDE: begin
                sw = 127;
                sh = 127;
            end
            default: begin
                sw = pick_size();
                sh = pick_size();
            end
        endcase
        if (kind == XF_WIDE) begin
            // Columns past the pitch read the next row; the last rows run off the store.
            tu = $urandom_range(64, 126);
            tv = $urandom_range(58, 66);
        end else begin
            tu = $urandom_range(0, (sw > 0 ? sw : 1) - 1);
            tv = $urandom_range(0, (sh > 0 ? sh : 1) - 1);
        end

        case (kind)
            XF_WIDE: begin
                au = 65536; bu = 0; av = 0; bv = 65536;
            end
            XF_AXIS: begin
                au = (longint'(65536) << $urandom_range(0, 2)) >> $urandom_range(0, 2);
                bv = (longint'(65536) << $urandom_range(0, 2)) >> $urandom_range(0, 2);
                if ($urandom_range(0, 1)) au = -au;
                if ($urandom_range(0, 1)) bv = -bv;
                bu = 0;
                av = 0;
            end
            XF_EXTREME: begin
                au = pick_extreme(); bu = pick_extreme();
                av = pick_extreme(); bv = pick_extreme();
            end
            default: begin
                au = longint'($urandom_range(0, 524288)) - 262144;
                bu = longint'($urandom_range(0, 524288)) - 262144;
                av = longint'($urandom_range(0, 524288)) - 262144;
                bv = longint'($urandom_range(0, 524288)) - 262144;
            end
        endcase

        if (kind == XF_EXTREME) begin
            ox = 0;
            oy = 0;
        end else begin
            ox = $urandom_range(0, 1023);
            oy = $urandom_range(0, 1023);
        end
        ou = (longint'(tu) <<< FRAC_BITS) + $urandom_range(0, 65535) - (au * ox + bu * oy);
        ov = (longint'(tv) <<< FRAC_BITS) + $urandom_range(0, 65535) - (av * ox + bv * oy);
        if (ou < S32_MIN || ou > S32_MAX) ou = longint'(int'($urandom));
        if (ov < S32_MIN || ov > S32_MAX) ov = longint'(int'($urandom));
        if (kind == XF_EXTREME && $urandom_range(0, 2) == 0) ou = pick_extreme();
        if (kind == XF_EXTREME && $urandom_range(0, 2) == 0) ov = pick_extreme();

        c.coef_u_from_x = au[31:0];
        c.coef_u_from_y = bu[31:0];
        c.offset_u = ou[31:0];
        c.coef_v_from_x = av[31:0];
        c.coef_v_from_y = bv[31:0];
        c.offset_v = ov[31:0];
        c.sprite_width = sw[SIZE_W-1:0];
        c.sprite_height = sh[SIZE_W-1:0];
        program_xform(c);

        made = 0;
        for (int i = 0; i < 4; i++)
            inks[i] = 8'($urandom);
        for (v = tv - 2; v <= tv + 2; v++) begin
            for (u = tu - 2; u <= tu + 2; u++) begin
                a = u + v * ROW_PITCH;
                if (u >= 0 && v >= 0 && a < TEX_DEPTH
                    && (!texel_loaded[a] || $urandom_range(0, 3) == 0)) begin
                    send_texel(a, {24'($urandom), inks[$urandom_range(0, 3)]});
                    made++;
                end
            end
        end
        for (int i = 0; i < 4; i++) begin
            send_palette(inks[i], $urandom);
            made++;
        end

        tries = 0;
        while (made < n_req && tries < 20 * n_req) begin
            tries++;
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
                queue_request(random_req(CMD_UNUSED));
            end else if (roll == 1) begin
                r = random_req(CMD_PALETTE);
                queue_request(r);
                if (r.address < PAL_DEPTH) made++;
            end else if (roll == 2) begin
                queue_request(random_req(CMD_TEXEL));
                made++;
            end else begin
                if (roll == 3) begin
                    x = $urandom_range(0, 1023);
                    y = $urandom_range(0, 1023);
                end else begin
                    x = ox + $urandom_range(0, 6) - 3;
                    y = oy + $urandom_range(0, 6) - 3;
                    x = x < 0 ? 0 : (x > 1023 ? 1023 : x);
                    y = y < 0 ? 0 : (y > 1023 ? 1023 : y);
                end
                key = ($urandom_range(0, 2) == 0) ? inks[$urandom_range(0, 3)] : KEY_W'($urandom);
                try_draw(x, y, key, sent);
                if (sent) made++;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [COLOR_W-1:0] want,
                               input logic [COLOR_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : request_driver
        bit load_next;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && o_ready)
                expected_writes.push_back(in_flight.wr);
            load_next = !i_valid || o_ready;
            if (load_next) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (blit_jobs.size() > 0) begin
                    in_flight = blit_jobs.pop_front();
                    i_valid <= 1'b1;
                    i_command <= in_flight.req.command;
                    i_address <= in_flight.req.address;
                    i_value <= in_flight.req.value;
                    i_dest_x <= in_flight.req.dest_x;
                    i_dest_y <= in_flight.req.dest_y;
                    i_transparent_index <= in_flight.req.key;
                    // The gap starts once this request has been taken.
                    if (!calm && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 12);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        pixel_write_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_writes.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request pending: expected none, actual %b %h %h %h",
                             $time, o_write_pixel, o_out_x, o_out_y, o_pixel_color);
                end else begin
                    want = expected_writes.pop_front();
                    check_field("write_pixel", want.write_pixel, o_write_pixel);
                    check_field("out_x", want.out_x, o_out_x);
                    check_field("out_y", want.out_y, o_out_y);
                    check_field("pixel_color", want.pixel_color, o_pixel_color);
                end
            end
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                recv_stall <= $urandom_range(0, 11);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("affine_sprite_blit regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        bit sent;
        t_item r;
        xform.coef_u_from_x = 32'd65536;
        xform.coef_u_from_y = '0;
        xform.offset_u = '0;
        xform.coef_v_from_x = '0;
        xform.coef_v_from_y = 32'd65536;
        xform.offset_v = '0;
        xform.sprite_width = 7'd64;
        xform.sprite_height = 7'd64;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset mapping (identity, 64x64 sprite).
        send_texel(0, 32'hFFFF_FF00);
        send_texel(TEX_DEPTH - 1, 32'h0000_00FF);
        send_texel(1, 32'h0000_00A5);
        send_palette(0, 32'hFFFF_FFFF);
        send_palette(255, 32'h0000_0000);
        send_palette(8'hA5, 32'h5A5A_5A5A);
        send_palette(256, 32'h1234_5678);
        send_palette(4095, 32'h8765_4321);
        r = random_req(CMD_UNUSED);
        r.address = '1; r.value = '1; r.dest_x = '1; r.dest_y = '1; r.key = '1;
        queue_request(r);
        queue_request(random_req(CMD_UNUSED));
        try_draw(0, 0, 8'h01, sent);
        try_draw(0, 0, 8'h00, sent);       // transparent texel
        try_draw(63, 63, 8'h00, sent);     // last texel, color of all zeros
        try_draw(63, 63, 8'hFF, sent);
        try_draw(1, 0, 8'hA5, sent);
        try_draw(1, 0, 8'h00, sent);
        try_draw(64, 0, 8'h00, sent);      // just past the sprite width
        try_draw(0, 64, 8'h00, sent);      // just past the sprite height
        try_draw(1023, 1023, 8'h00, sent);
        try_draw(1023, 0, 8'h00, sent);
        send_texel(1, 32'h1234_5600);      // only the low byte is the texel
        try_draw(1, 0, 8'hA5, sent);

        run_phase(XF_EMPTY, 30);
        run_phase(XF_WIDE, 80);
        run_phase(XF_EXTREME, 40);
        for (int p = 0; p < 8; p++) begin
            if (p == 7)
                calm = 1'b1;
            run_phase(p % 2 ? XF_AXIS : XF_RANDOM, 70);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("affine_sprite_blit regression: pass");
        else
            $display("affine_sprite_blit regression: fail");
        $finish;
    end

endmodule

// ===== affine_sprite_blit.f =====
+incdir+rtl/core
rtl/core/asb_pkg.sv
rtl/core/asb_xform.sv
rtl/core/asb_texfetch.sv
rtl/core/asb_palout.sv
rtl/core/affine_sprite_blit.sv
test/affine_sprite_blit_tb.sv
